>>> design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg : shared constants for the scalar Kalman filter
// Field widths, fixed-point formats, register indexes and reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int MEAS_W    = 16;   // measurement / estimate, int16
  localparam int FRAC_W    = 16;   // Q16.16 fraction bits
  localparam int STATE_W   = 32;   // x, p, Q, R
  localparam int GAIN_W    = 16;   // gain, Q0.16
  localparam int DEN_W     = STATE_W + 1;
  localparam int REM_W     = STATE_W + 2;
  localparam int QUO_W     = GAIN_W + 1;
  localparam int DIFF_W    = STATE_W + 2;
  localparam int MULA_W    = GAIN_W + 2;
  localparam int PROD_W    = MULA_W + DIFF_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;

  localparam logic [STATE_W-1:0] PROCESS_NOISE_RST = 32'd66;
  localparam logic [STATE_W-1:0] MEASURE_NOISE_RST = 32'd65536;

  localparam logic [GAIN_W:0]     GAIN_ONE = 17'h10000;
  localparam logic [GAIN_W-1:0]   GAIN_MAX = 16'hFFFF;

endpackage

>>> design/skf_gain_div.sv
// ----------------------------------------------------------------------------
// skf_gain_div : radix-2 restoring divider for the Kalman gain
// gain = floor(num * 2^16 / den), capped at 0xFFFF, zero when den is zero.
// One quotient bit per cycle, 17 steps; done pulses with gain valid.
// ----------------------------------------------------------------------------
module skf_gain_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [skf_pkg::STATE_W-1:0]   num,
  input  logic [skf_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [skf_pkg::GAIN_W-1:0]    gain
);
  import skf_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(QUO_W - 1);

  logic                active;
  logic [4:0]          cnt;
  logic [REM_W-1:0]    rem;
  logic [QUO_W-2:0]    quo;
  logic [DEN_W-1:0]    den_r;
  logic                den_zero;
  logic [REM_W-1:0]    rem_s;
  logic                ge;
  logic [QUO_W-1:0]    quo_full;

  always_comb begin
    rem_s    = (cnt == 5'd0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge       = rem_s >= {1'b0, den_r};
    quo_full = {quo, ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= '0;
        rem      <= {2'b00, num};
        quo      <= '0;
        den_r    <= den;
        den_zero <= (den == '0);
      end else if (active) begin
        rem <= ge ? (rem_s - {1'b0, den_r}) : rem_s;
        quo <= quo_full[QUO_W-2:0];
        cnt <= cnt + 5'd1;
        if (cnt == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
          if (den_zero)
            gain <= '0;
          else if (quo_full[QUO_W-1])
            gain <= GAIN_MAX;
          else
            gain <= quo_full[GAIN_W-1:0];
        end
      end
    end
  end

endmodule

>>> design/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter : one-dimensional Kalman filter, A = H = 1
// Takes one measurement at a time (in_stall is high outside idle); the work
// is done by the 17-step radix-2 gain divider and one shared 18x34 multiplier
// used twice. Synchronous reset clears the estimate and covariance, sets
// Q = 66 and R = 65536 (Q16.16), and empties the output.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skf_pkg::STATE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [skf_pkg::MEAS_W-1:0] measurement,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [skf_pkg::MEAS_W-1:0] estimate
);
  import skf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULX = 3'd3;
  localparam logic [2:0] ST_MULP = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int SUM_W = STATE_W + 5;

  logic [2:0]                 state;
  logic [STATE_W-1:0]         process_noise;
  logic [STATE_W-1:0]         measure_noise;
  logic signed [STATE_W-1:0]  est_value;
  logic [STATE_W-1:0]         err_cov;
  logic signed [MEAS_W-1:0]   z;
  logic [STATE_W-1:0]         p1;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;

  logic [STATE_W:0]           p_sum;
  logic [STATE_W-1:0]         p1_next;
  logic [DEN_W-1:0]           den_next;
  logic signed [DIFF_W-1:0]   diff_next;
  logic                       div_start;
  logic                       div_done;
  logic [GAIN_W-1:0]          gain;
  logic signed [MULA_W-1:0]   mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [SUM_W-1:0]    nx;
  logic signed [STATE_W-1:0]  x_next;
  logic                       out_free;
  logic signed [MEAS_W-1:0]   est_int;

  skf_gain_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p1_next),
    .den   (den_next),
    .done  (div_done),
    .gain  (gain)
  );

  always_comb begin
    p_sum     = {1'b0, err_cov} + {1'b0, process_noise};
    p1_next   = p_sum[STATE_W] ? '1 : p_sum[STATE_W-1:0];
    den_next  = {1'b0, p1_next} + {1'b0, measure_noise};
    diff_next = {{(DIFF_W-STATE_W){z[MEAS_W-1]}}, z, {FRAC_W{1'b0}}}
              - {{(DIFF_W-STATE_W){est_value[STATE_W-1]}}, est_value};
    div_start = (state == ST_PRED);

    if (state == ST_MULX) begin
      mul_a = {2'b00, gain};
      mul_b = diff;
    end else begin
      mul_a = {1'b0, GAIN_ONE - {1'b0, gain}};
      mul_b = {2'b00, p1};
    end

    // floor(g * d / 2^16) is an arithmetic shift
    nx = {{(SUM_W-STATE_W){est_value[STATE_W-1]}}, est_value}
       + {{(SUM_W-(PROD_W-FRAC_W)){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};
    if (nx > SUM_W'(32'sh7FFF_FFFF))
      x_next = 32'sh7FFF_FFFF;
    else if (nx < -SUM_W'(64'sh8000_0000))
      x_next = 32'sh8000_0000;
    else
      x_next = nx[STATE_W-1:0];

    // truncate toward zero
    if (est_value[STATE_W-1] && (est_value[FRAC_W-1:0] != '0))
      est_int = est_value[STATE_W-1:FRAC_W] + MEAS_W'(1);
    else
      est_int = est_value[STATE_W-1:FRAC_W];

    out_free = !out_valid || !out_stall;
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      est_value     <= '0;
      err_cov       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: process_noise <= cfg_data;
          CFG_MEASURE_NOISE: measure_noise <= cfg_data;
          default: ;
        endcase
      end

      // in ST_DONE the output register is reloaded below
      if (out_valid && !out_stall && (state != ST_DONE))
        out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            z     <= measurement;
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          p1    <= p1_next;
          diff  <= diff_next;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done)
            state <= ST_MULX;
        end
        ST_MULX: begin
          prod  <= mul_a * mul_b;
          state <= ST_MULP;
        end
        ST_MULP: begin
          est_value <= x_next;
          prod      <= mul_a * mul_b;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          err_cov <= prod[FRAC_W +: STATE_W];
          if (out_free) begin
            estimate  <= est_int;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
